@@ src/crcfcs_pkg.sv @@
// Shared types and constants for the CRC-32 frame check sequence engine.
`default_nettype none

package crcfcs_pkg;

  localparam int unsigned CrcW      = 32;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned AppendLen = CrcW / ByteW;
  localparam int unsigned AppCntW   = $clog2(AppendLen + 1);

  localparam logic [CrcW-1:0] CrcPoly = 32'h04C1_1DB7;
  localparam logic [CrcW-1:0] CrcInit = '0;

  localparam logic ModeGenerate = 1'b0;
  localparam logic ModeCheck    = 1'b1;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             frame_last;
  } in_item_t;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             is_crc_byte;
    logic             frame_done;
    logic             crc_ok;
    logic             run_last;
  } out_item_t;

endpackage

`default_nettype wire

@@ src/crc32_frame_fcs_gen_check_unit.sv @@
// Top level of the CRC-32 frame check sequence generator and checker.
`default_nettype none

// CRC-32 frame check sequence engine (MSB first, polynomial 0x04C11DB7,
// initial value zero, no final inversion, no bit reflection). Each input beat
// carries one frame byte; the byte is folded into the running CRC and passed
// to the output through a single result register, so the engine takes one byte
// per clock whenever the output side keeps up and no CRC append is draining.
// In generate mode (mode = 0) the last byte of a frame is followed by the four
// CRC bytes, most significant first; while those four beats drain, in_ready
// stays low, so a generated frame of N bytes leaves as N + 4 output beats.
// In check mode (mode = 1) the received CRC bytes are part of the stream and
// the beat carrying the last byte reports crc_ok, which is set when the
// residue is zero. The running CRC is cleared after every frame. The mode
// register is written through the cfg port, which is always ready; write it
// only while the engine is idle. The throughput limit is the output register:
// one beat leaves per cycle while out_ready is high, and the CRC update itself
// is one combinational byte step in front of that register.

module crc32_frame_fcs_gen_check_unit (
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_data,

  input  logic                  in_valid,
  output logic                  in_ready,
  input  crcfcs_pkg::in_item_t  in_data,

  output logic                  out_valid,
  input  logic                  out_ready,
  output crcfcs_pkg::out_item_t out_data
);
  import crcfcs_pkg::*;

  // Control state.
  logic               mode_r;
  logic [CrcW-1:0]    crc_r,       crc_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [AppCntW-1:0] app_cnt_r,   app_cnt_nxt;

  // Payload state.
  out_item_t          out_data_r,  out_data_nxt;
  logic [CrcW-1:0]    app_crc_r,   app_crc_nxt;

  logic [CrcW-1:0]    crc_upd;
  logic               slot_free;
  logic               app_busy;
  logic               in_fire;

  crcfcs_byte_update u_upd (
    .crc_in    (crc_r),
    .data_byte (in_data.data_byte),
    .crc_out   (crc_upd)
  );

  // The result register can take a new beat when it is empty or being drained.
  assign slot_free = !out_valid_r || out_ready;
  assign app_busy  = (app_cnt_r != '0);
  assign in_ready  = slot_free && !app_busy;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    crc_nxt       = crc_r;
    out_valid_nxt = out_valid_r && !out_ready;
    app_cnt_nxt   = app_cnt_r;
    out_data_nxt  = out_data_r;
    app_crc_nxt   = app_crc_r;

    if (slot_free && app_busy) begin
      // Drain the appended CRC, top byte first.
      out_valid_nxt            = 1'b1;
      out_data_nxt.out_byte    = app_crc_r[CrcW-1 -: ByteW];
      out_data_nxt.is_crc_byte = 1'b1;
      out_data_nxt.frame_done  = (app_cnt_r == AppCntW'(1));
      out_data_nxt.crc_ok      = 1'b0;
      out_data_nxt.run_last    = (app_cnt_r == AppCntW'(1));
      app_crc_nxt              = {app_crc_r[CrcW-ByteW-1:0], {ByteW{1'b0}}};
      app_cnt_nxt              = app_cnt_r - AppCntW'(1);
    end else if (in_fire) begin
      out_valid_nxt            = 1'b1;
      out_data_nxt.out_byte    = in_data.data_byte;
      out_data_nxt.is_crc_byte = 1'b0;
      out_data_nxt.frame_done  = 1'b0;
      out_data_nxt.crc_ok      = 1'b0;
      out_data_nxt.run_last    = 1'b1;
      if (!in_data.frame_last) begin
        crc_nxt = crc_upd;
      end else if (mode_r == ModeCheck) begin
        out_data_nxt.frame_done = 1'b1;
        out_data_nxt.crc_ok     = (crc_upd == '0);
        crc_nxt                 = CrcInit;
      end else begin
        // The CRC bytes follow this beat; it is not the last one of its run.
        out_data_nxt.run_last = 1'b0;
        app_crc_nxt           = crc_upd;
        app_cnt_nxt           = AppCntW'(AppendLen);
        crc_nxt               = CrcInit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= ModeGenerate;
      crc_r       <= CrcInit;
      out_valid_r <= 1'b0;
      app_cnt_r   <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        mode_r <= cfg_data;
      end
      crc_r       <= crc_nxt;
      out_valid_r <= out_valid_nxt;
      app_cnt_r   <= app_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    app_crc_r  <= app_crc_nxt;
  end

endmodule

`default_nettype wire

@@ src/crcfcs_byte_update.sv @@
// Byte-wide CRC-32 update, MSB first, polynomial from the package.
`default_nettype none

module crcfcs_byte_update (
  input  logic [crcfcs_pkg::CrcW-1:0]  crc_in,
  input  logic [crcfcs_pkg::ByteW-1:0] data_byte,
  output logic [crcfcs_pkg::CrcW-1:0]  crc_out
);
  import crcfcs_pkg::*;

  // Eight shift-and-reduce steps, one per input bit, leading bit first.
  always_comb begin
    logic [CrcW-1:0] acc;
    acc = crc_in ^ {data_byte, {(CrcW-ByteW){1'b0}}};
    for (int b = 0; b < ByteW; b++) begin
      if (acc[CrcW-1]) begin
        acc = {acc[CrcW-2:0], 1'b0} ^ CrcPoly;
      end else begin
        acc = {acc[CrcW-2:0], 1'b0};
      end
    end
    crc_out = acc;
  end

endmodule

`default_nettype wire

@@ src/crcfcs_checker.sv @@
// Port-level assertions for the frame check sequence engine, bound to the top.
`default_nettype none

module crcfcs_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input crcfcs_pkg::in_item_t  in_data,
  input logic                  out_valid,
  input logic                  out_ready,
  input crcfcs_pkg::out_item_t out_data
);
  import crcfcs_pkg::*;

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // A non-final frame byte produces exactly one beat, in the next cycle.
  a_byte_pass: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_data.frame_last |=>
      out_valid && out_data.run_last && !out_data.is_crc_byte &&
      (out_data.out_byte == $past(in_data.data_byte)))
    else $error("frame byte not passed through");

  // Appended CRC bytes come back to back once the sink takes them.
  a_crc_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_data.run_last |=>
      out_valid && out_data.is_crc_byte)
    else $error("gap inside the appended CRC bytes");

  // No new byte is taken while a multi-beat run is still draining.
  a_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.run_last |-> !in_ready)
    else $error("input accepted during CRC append");

  // crc_ok only appears on a frame's final beat.
  a_ok_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.crc_ok |-> out_data.frame_done && !out_data.is_crc_byte)
    else $error("crc_ok outside a frame end");

endmodule

bind crc32_frame_fcs_gen_check_unit crcfcs_checker u_crcfcs_checker (.*);

`default_nettype wire

@@ tb/sv/crc32_frame_fcs_gen_check_unit_test.sv @@
// Self-checking testbench for the CRC-32 frame check sequence generator and checker.
`default_nettype none

module crc32_frame_fcs_gen_check_unit_test;
  import crcfcs_pkg::*;

  // The watchdog limit leaves a wide margin over what a run of a few hundred
  // bytes with stalls needs.
  localparam int unsigned CycleLimit = 200000;
  // The engine has one output register, so the settle wait after the last
  // expected beat covers anything still in flight.
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned RandomPhases = 12;
  localparam int unsigned BytesPerPhase = 20;

  logic      clk;
  logic      rst_n;
  logic      cfg_valid;
  logic      cfg_ready;
  logic      cfg_data;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  crc32_frame_fcs_gen_check_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Shadow copy of the engine state: the running CRC and the mode register.
  logic [CrcW-1:0] run_crc;
  logic            cur_mode;

  // Output beats that the accepted input bytes must still produce, oldest first.
  out_item_t out_beats_due[$];

  // Bytes of the frame that a test is about to send.
  logic [ByteW-1:0] frame_buf[$];

  // When this is low, neither side inserts idle or stall cycles.
  bit idle_on;

  int unsigned cycle_cnt;
  int unsigned fail_cnt;
  int unsigned beats_in;
  int unsigned beats_out;
  int unsigned frames_gen;
  int unsigned frames_chk;
  int unsigned frames_chk_ok;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // One byte step of the MSB-first CRC: the byte enters at the top of the
  // register and eight shifts reduce it by the polynomial.
  function automatic logic [CrcW-1:0] fold_byte(input logic [CrcW-1:0] crc,
                                                input logic [ByteW-1:0] b);
    logic [CrcW-1:0] acc;
    acc = crc ^ {b, 24'h0};
    for (int i = 0; i < 8; i++) begin
      if (acc[CrcW-1]) begin
        acc = (acc << 1) ^ CrcPoly;
      end else begin
        acc = acc << 1;
      end
    end
    return acc;
  endfunction

  // CRC of the whole frame buffer, starting from a cleared register.
  function automatic logic [CrcW-1:0] fcs_of_buf();
    logic [CrcW-1:0] acc;
    acc = CrcInit;
    foreach (frame_buf[i]) begin
      acc = fold_byte(acc, frame_buf[i]);
    end
    return acc;
  endfunction

  // Appends the frame's own CRC, most significant byte first, so that a
  // checker sees a zero residue.
  task automatic append_fcs();
    logic [CrcW-1:0] f;
    f = fcs_of_buf();
    for (int k = 0; k < AppendLen; k++) begin
      frame_buf.push_back(f[CrcW-1-8*k -: 8]);
    end
  endtask

  // Works out the output beats that one accepted byte causes and updates the
  // shadow CRC. A byte that is not last just passes through. A last byte in
  // check mode reports the residue; in generate mode it is followed by the
  // four CRC bytes. Either way the CRC restarts from zero after a frame.
  task automatic predict_beats(input in_item_t it);
    logic [CrcW-1:0] nxt;
    out_item_t       r;
    nxt = fold_byte(run_crc, it.data_byte);
    r = '0;
    r.out_byte = it.data_byte;
    if (!it.frame_last) begin
      run_crc = nxt;
      r.run_last = 1'b1;
      out_beats_due.push_back(r);
    end else if (cur_mode == ModeCheck) begin
      r.frame_done = 1'b1;
      r.crc_ok     = (nxt == '0);
      r.run_last   = 1'b1;
      out_beats_due.push_back(r);
      run_crc = CrcInit;
      frames_chk++;
      if (nxt == '0) begin
        frames_chk_ok++;
      end
    end else begin
      out_beats_due.push_back(r);
      for (int k = 0; k < AppendLen; k++) begin
        r.out_byte    = nxt[CrcW-1-8*k -: 8];
        r.is_crc_byte = 1'b1;
        r.frame_done  = (k == AppendLen - 1);
        r.run_last    = (k == AppendLen - 1);
        out_beats_due.push_back(r);
      end
      run_crc = CrcInit;
      frames_gen++;
    end
  endtask

  // Presents one byte on the input channel, after an optional short idle
  // burst, and holds it until the engine takes it. The beat stays valid on
  // return; the next call either replaces it or a drain lowers valid.
  task automatic send_byte(input logic [ByteW-1:0] b, input logic last);
    in_item_t    it;
    int unsigned gap;
    it.data_byte  = b;
    it.frame_last = last;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    beats_in++;
    predict_beats(it);
  endtask

  // Sends the frame buffer. With close set the final byte ends the frame,
  // otherwise the frame stays open for later bytes.
  task automatic send_frame_buf(input bit close);
    foreach (frame_buf[i]) begin
      send_byte(frame_buf[i], close && (i == frame_buf.size() - 1));
    end
  endtask

  // Lowers valid, waits for every predicted beat and lets the output
  // register settle, which leaves the engine idle for a mode write.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (out_beats_due.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Writes the mode register; call only while the engine is idle.
  task automatic write_mode(input logic m);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    do @(posedge clk); while (!cfg_ready);
    cur_mode = m;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic check_field(input string what, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: mismatch on %s, expected %0h, actual %0h", $time, what, want, got);
      fail_cnt++;
    end
  endtask

  // The receiver stalls in random bursts while idling is on.
  initial begin : out_stall_gen
    int unsigned stall_left;
    stall_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        stall_left = $urandom_range(1, 3) - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Every output beat taken at a rising edge is compared with the oldest
  // predicted beat. The same block runs the watchdog.
  always @(posedge clk) begin : out_beat_check
    out_item_t want;
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("%0t: watchdog expired with %0d beats still due", $time, out_beats_due.size());
      $display("Regression FAIL");
      $finish;
    end else if (rst_n && out_valid && out_ready) begin
      beats_out++;
      if (out_beats_due.size() == 0) begin
        $display("%0t: unexpected output beat, expected none, actual %h", $time, out_data);
        fail_cnt++;
      end else begin
        want = out_beats_due.pop_front();
        check_field("out_byte", want.out_byte, out_data.out_byte);
        check_field("is_crc_byte", want.is_crc_byte, out_data.is_crc_byte);
        check_field("frame_done", want.frame_done, out_data.frame_done);
        check_field("crc_ok", want.crc_ok, out_data.crc_ok);
        check_field("run_last", want.run_last, out_data.run_last);
      end
    end
  end

  // Generate mode on short frames: an all-zero byte gives a zero CRC, and
  // all-ones and single-bit bytes exercise the polynomial feedback.
  task automatic test_generate_basics();
    write_mode(ModeGenerate);
    frame_buf = '{8'h00};
    send_frame_buf(1);
    frame_buf = '{8'hFF};
    send_frame_buf(1);
    frame_buf = '{8'h80, 8'h01, 8'h7F};
    send_frame_buf(1);
    frame_buf = '{8'hFF, 8'hFF, 8'hFF};
    send_frame_buf(1);
    drain();
  endtask

  // Check mode: a lone zero byte leaves a zero residue, a frame followed by
  // its own CRC passes, and another such frame with one flipped bit fails.
  task automatic test_check_basics();
    write_mode(ModeCheck);
    frame_buf = '{8'h00};
    send_frame_buf(1);
    frame_buf = '{8'hFF};
    append_fcs();
    send_frame_buf(1);
    frame_buf = '{8'h55};
    append_fcs();
    frame_buf[2] ^= 8'h10;
    send_frame_buf(1);
    drain();
  endtask

  // A mode write in the middle of a frame takes effect at once and keeps
  // the running CRC, so the frame closes under the new mode.
  task automatic test_mode_switch_in_frame();
    logic [CrcW-1:0] f;
    write_mode(ModeGenerate);
    frame_buf = '{8'h12, 8'h34};
    f = fcs_of_buf();
    send_frame_buf(0);
    drain();
    write_mode(ModeCheck);
    frame_buf = '{f[31:24], f[23:16], f[15:8], f[7:0]};
    send_frame_buf(1);
    frame_buf = '{8'hC3};
    send_frame_buf(0);
    drain();
    write_mode(ModeGenerate);
    frame_buf = '{8'h3C};
    send_frame_buf(1);
    drain();
  endtask

  // Random phases, each under one mode. Most frames are well formed with
  // random content; in check mode some carry a corrupted byte, and a few
  // stretches are plain noise whose frame ends fall at random, which can
  // leave a frame open across a mode change. The last phase runs with no
  // idling on either side.
  task automatic test_random_traffic();
    int unsigned phase_start;
    int unsigned len;
    int unsigned kind;
    logic        m;
    for (int ph = 0; ph < RandomPhases; ph++) begin
      m = (ph < 2) ? logic'(ph) : logic'($urandom_range(0, 1));
      if (ph == RandomPhases - 1) begin
        idle_on = 0;
      end
      write_mode(m);
      phase_start = beats_in;
      while (beats_in - phase_start < BytesPerPhase) begin
        kind = $urandom_range(0, 9);
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
        frame_buf.delete();
        repeat (len) frame_buf.push_back(8'($urandom_range(0, 255)));
        if (kind == 0) begin
          foreach (frame_buf[i]) begin
            send_byte(frame_buf[i], $urandom_range(0, 4) == 0);
          end
        end else begin
          if (m == ModeCheck) begin
            append_fcs();
            if (kind < 3) begin
              frame_buf[$urandom_range(0, frame_buf.size() - 1)] ^=
                8'(1 << $urandom_range(0, 7));
            end
          end
          send_frame_buf(1);
        end
      end
      drain();
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    idle_on   = 1;
    run_crc   = CrcInit;
    cur_mode  = ModeGenerate;
    cycle_cnt = 0;
    fail_cnt  = 0;
    beats_in  = 0;
    beats_out = 0;
    frames_gen    = 0;
    frames_chk    = 0;
    frames_chk_ok = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_generate_basics();
    test_check_basics();
    test_mode_switch_in_frame();
    test_random_traffic();

    $display("Sent %0d bytes and took %0d output beats over %0d generated frames.",
             beats_in, beats_out, frames_gen);
    $display("Checked %0d received frames, %0d of them with a zero residue.",
             frames_chk, frames_chk_ok);
    if (fail_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ files.f @@
src/crcfcs_pkg.sv
src/crcfcs_byte_update.sv
src/crc32_frame_fcs_gen_check_unit.sv
src/crcfcs_checker.sv
tb/sv/crc32_frame_fcs_gen_check_unit_test.sv
